FILE: rtl/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Checks that a condition implies a property at the same edge.
`define CHK_IMPL(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);
// Checks that a condition implies a property at the next edge.
`define CHK_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);
`endif

FILE: rtl/lsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package lsc_pkg;
  localparam int unsigned NUM_SLOTS_DEF = 64;
  localparam int unsigned QUANTUM_DEF = 50;
  localparam logic [9:0] TICKET_MAX = 10'd1023;

  typedef enum logic [1:0] {
    ST_NONE = 2'd0, ST_READY = 2'd1, ST_RUNNING = 2'd2, ST_STOPPED = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    FN_READY = 2'd0, FN_RESUME = 2'd1, FN_STOP = 2'd2, FN_YIELD = 2'd3
  } func_t;

  localparam logic [2:0] USER_CLASS = 3'd7;

  typedef enum logic [3:0] {
    S_IDLE, S_GRANT, S_DIV, S_SUM, S_MOD, S_PICK, S_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [5:0]  slot;
    logic [2:0]  prio_class;
    logic [5:0]  ticks_left;
    logic [15:0] random_value;
  } in_word_t;

  typedef struct packed {
    logic [5:0]  chosen_slot;
    logic        chose_idle;
    logic [15:0] total_tickets;
    logic [9:0]  granted_tickets;
  } out_word_t;

  // Command to the cell row.
  typedef struct packed {
    logic       shift;   // rotate the row by one cell
    logic       wr;      // write the head cell
    logic [1:0] wr_st;
    logic [9:0] wr_tk;
    logic [2:0] wr_pr;
  } row_cmd_t;

  function automatic logic [4:0] base_tickets(input logic [2:0] p);
    logic [4:0] r;
    unique case (p)
      3'd0: r = 5'd16;
      3'd1: r = 5'd14;
      3'd2: r = 5'd12;
      3'd3: r = 5'd10;
      3'd4: r = 5'd8;
      3'd5: r = 5'd6;
      3'd6: r = 5'd4;
      default: r = 5'd2;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

FILE: rtl/lsc_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module lsc_cell
  import lsc_pkg::*;
(
  input  wire        clk,
  input  wire        rst,
  input  wire        shift,
  input  wire        load,
  input  wire  [1:0] in_st,
  input  wire  [9:0] in_tk,
  input  wire  [2:0] in_pr,
  output logic [1:0] st,
  output logic [9:0] tk,
  output logic [2:0] pr
);
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_NONE;
      tk <= '0;
      pr <= USER_CLASS;
    end else if (shift || load) begin
      st <= in_st;
      tk <= in_tk;
      pr <= in_pr;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/lsc_row.sv
`timescale 1ns / 1ps
`default_nettype none
// Ring of cells; cell 0 is the head. A shift moves cell i+1 into cell i.
module lsc_row
  import lsc_pkg::*;
#(
  parameter int unsigned NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  wire             clk,
  input  wire             rst,
  input  row_cmd_t        cmd,
  output logic [1:0]      head_st,
  output logic [9:0]      head_tk,
  output logic [2:0]      head_pr
);
  logic [1:0] st [NUM_SLOTS];
  logic [9:0] tk [NUM_SLOTS];
  logic [2:0] pr [NUM_SLOTS];

  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
    localparam int unsigned NXT = (i + 1) % NUM_SLOTS;
    logic [1:0] ist;
    logic [9:0] itk;
    logic [2:0] ipr;
    if (i == 0) begin : g_head
      assign ist = cmd.wr ? cmd.wr_st : st[NXT];
      assign itk = cmd.wr ? cmd.wr_tk : tk[NXT];
      assign ipr = cmd.wr ? cmd.wr_pr : pr[NXT];
    end else begin : g_body
      assign ist = st[NXT];
      assign itk = tk[NXT];
      assign ipr = pr[NXT];
    end
    lsc_cell u_cell (
      .clk(clk), .rst(rst), .shift(cmd.shift), .load(i == 0 && cmd.wr),
      .in_st(ist), .in_tk(itk), .in_pr(ipr),
      .st(st[i]), .tk(tk[i]), .pr(pr[i])
    );
  end

  assign head_st = st[0];
  assign head_tk = tk[0];
  assign head_pr = pr[0];
endmodule
`default_nettype wire

FILE: rtl/lottery_scheduler_compensation.sv
`timescale 1ns / 1ps
`default_nettype none
// Lottery scheduler with compensation tickets.
// Command channel: drive start high with cmd while busy is low; the word is
// taken at that edge and busy rises. Exactly one result word per command
// appears on res for one cycle with done high; the receiver cannot stall.
// The slot table is a ring of NUM_SLOTS cells that rotates one place per
// cycle while it shifts, so every slot access walks to the slot through the
// ring head. Make ready / resume: rotate to the slot, then a restoring
// divide for the compensation, with no divide without it. Draw: rotate to
// the running slot and regrant it on a yield (same divide) or mark it
// stopped on a stop, one full turn summing tickets, a modulo that also
// turns the ring back to slot 0, and a turn of the ring picking the winner.
// busy is low in the done cycle, so the next word can be taken at the edge
// that ends it. Reset empties every slot, sets all classes to user class
// and leaves idle running; the block is ready right after reset.
module lottery_scheduler_compensation
  import lsc_pkg::*;
#(
  parameter int unsigned NUM_SLOTS = NUM_SLOTS_DEF,
  parameter int unsigned QUANTUM   = QUANTUM_DEF
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        start,
  input  in_word_t   cmd,
  output logic       busy,
  output logic       done,
  output out_word_t  res
);
  localparam int unsigned SW = $clog2(NUM_SLOTS);
  localparam int unsigned CW = SW + 1;
  localparam logic [7:0] QV = 8'(QUANTUM);

  state_t   state, state_next;
  in_word_t req;
  logic [CW-1:0] pos, cnt;          // pos: slot currently at head
  logic [SW-1:0] target;
  logic          running_valid;
  logic [SW-1:0] running_slot;
  logic          is_draw, do_grant, has_grant;
  logic [17:0]   sum;
  logic [17:0]   acc;
  logic [17:0]   rem;               // divide / modulo remainder
  logic [15:0]   quo;
  logic [4:0]    dcnt;
  logic [9:0]    granted;
  logic [SW-1:0] pick;
  logic          found;
  logic [9:0]    grant_tk;
  row_cmd_t      rc;
  logic [1:0]    head_st;
  logic [9:0]    head_tk;
  logic [2:0]    head_pr;
  logic [12:0]   dividend;
  logic [7:0]    used;

  lsc_row #(.NUM_SLOTS(NUM_SLOTS)) u_row (
    .clk(clk), .rst(rst), .cmd(rc),
    .head_st(head_st), .head_tk(head_tk), .head_pr(head_pr)
  );

  assign used = QV - {2'b0, req.ticks_left};
  assign grant_tk = (quo > 16'(TICKET_MAX)) ? TICKET_MAX : quo[9:0];
  wire at_target = (pos[SW-1:0] == target);
  wire [2:0] gp = (req.func == FN_READY) ? req.prio_class : head_pr;
  wire comp = ({2'b0, req.ticks_left} < QV);

  always_comb begin
    unique case (req.func)
      FN_READY: do_grant = 1'b1;
      FN_RESUME: do_grant = (head_st == ST_STOPPED);
      FN_STOP: do_grant = 1'b0;
      default: do_grant = (head_st == ST_RUNNING);
    endcase
  end

  always_comb begin
    state_next = state;
    rc = '0;
    rc.wr_st = ST_READY;
    rc.wr_tk = grant_tk;
    rc.wr_pr = gp;
    unique case (state)
      S_IDLE: if (start) state_next = S_GRANT;
      S_GRANT: begin
        if (!has_grant) state_next = is_draw ? S_SUM : S_DONE;
        else if (!at_target) rc.shift = 1'b1;
        else if (!do_grant) begin
          // A stop marks the running slot stopped in place before the draw.
          if (req.func == FN_STOP) begin
            rc.wr = 1'b1;
            rc.wr_st = ST_STOPPED;
            rc.wr_tk = head_tk;
            rc.wr_pr = head_pr;
          end
          state_next = is_draw ? S_SUM : S_DONE;
        end
        else state_next = S_DIV;
      end
      S_DIV: if (dcnt == 5'd0) begin
        rc.wr = 1'b1;
        state_next = is_draw ? S_SUM : S_DONE;
      end
      S_SUM: begin
        rc.shift = 1'b1;
        if (cnt == CW'(NUM_SLOTS - 1)) state_next = S_MOD;
      end
      S_MOD: begin
        // The ring turns back to slot 0 while the modulo runs.
        if (pos != '0) rc.shift = 1'b1;
        if (sum == 18'd0) state_next = S_DONE;
        else if (dcnt == 5'd0 && pos == '0) state_next = S_PICK;
      end
      S_PICK: begin
        rc.shift = 1'b1;
        if (!found && head_st == ST_READY && acc + 18'(head_tk) > rem) begin
          rc.shift = 1'b0;
          rc.wr = 1'b1;
          rc.wr_st = ST_RUNNING;
          rc.wr_tk = head_tk;
          rc.wr_pr = USER_CLASS;
        end
        if (cnt == CW'(NUM_SLOTS - 1)) state_next = S_DONE;
      end
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      running_valid <= 1'b0;
      running_slot <= '0;
      done <= 1'b0;
    end else begin
      done <= (state == S_DONE);
      if (rc.shift) pos <= (pos == CW'(NUM_SLOTS - 1)) ? '0 : pos + 1'b1;
      if (state == S_DONE && is_draw) begin
        running_valid <= found;
        if (found) running_slot <= pick;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: if (start) begin
        req <= cmd;
        is_draw <= cmd.func[1];
        granted <= '0;
        cnt <= '0;
        sum <= '0;
        acc <= '0;
        found <= 1'b0;
        pick <= '0;
        if (cmd.func[1]) begin
          target <= running_slot;
          has_grant <= running_valid;
        end else begin
          target <= SW'(cmd.slot);
          has_grant <= (7'(cmd.slot) < 7'(NUM_SLOTS)) || (NUM_SLOTS >= 64);
        end
      end
      S_GRANT: if (has_grant && at_target) begin
        // Set up the compensation divide for the head slot.
        dividend <= 13'(base_tickets(gp)) * 13'(QV);
        quo <= comp ? 16'd0 : 16'(base_tickets(gp));
        rem <= '0;
        dcnt <= 5'd13;
      end
      S_DIV: begin
        if (comp) begin
          if (dcnt != 5'd0) begin
            if ({rem[16:0], dividend[12]} >= 18'(used)) begin
              rem <= {rem[16:0], dividend[12]} - 18'(used);
              quo <= {quo[14:0], 1'b1};
            end else begin
              rem <= {rem[16:0], dividend[12]};
              quo <= {quo[14:0], 1'b0};
            end
            dividend <= {dividend[11:0], 1'b0};
            dcnt <= dcnt - 1'b1;
          end
        end else dcnt <= 5'd0;
        if (dcnt == 5'd0 && !is_draw) granted <= grant_tk;
      end
      S_SUM: begin
        if (head_st == ST_READY) sum <= sum + 18'(head_tk);
        cnt <= (cnt == CW'(NUM_SLOTS - 1)) ? '0 : cnt + 1'b1;
        dividend <= '0;
        rem <= '0;
        quo <= {req.random_value};
        dcnt <= 5'd16;
      end
      S_MOD: if (dcnt != 5'd0) begin
        if ({rem[16:0], quo[15]} >= sum) rem <= {rem[16:0], quo[15]} - sum;
        else rem <= {rem[16:0], quo[15]};
        quo <= {quo[14:0], 1'b0};
        dcnt <= dcnt - 1'b1;
      end
      S_PICK: begin
        if (!found && head_st == ST_READY) begin
          if (acc + 18'(head_tk) > rem) begin
            found <= 1'b1;
            pick <= pos[SW-1:0];
          end
          acc <= acc + 18'(head_tk);
        end
        cnt <= (cnt == CW'(NUM_SLOTS - 1)) ? '0 : cnt + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE) begin
      res.granted_tickets <= is_draw ? 10'd0 : granted;
      res.chose_idle <= is_draw && !found;
      res.chosen_slot <= (is_draw && found) ? 6'(pick) : 6'd0;
      res.total_tickets <= !is_draw ? 16'd0 : (sum > 18'hFFFF) ? 16'hFFFF : sum[15:0];
    end
  end

  `include "assert_macros.svh"
  `CHK_NEXT(a_start_busy, clk, rst, start && !busy, busy, "start not taken")
  `CHK_NEXT(a_done_once, clk, rst, done, !done, "done held")
  `CHK_IMPL(a_done_idle, clk, rst, done, !busy, "done while busy")
endmodule
`default_nettype wire
